[hdl/lss_pkg.sv]
package lss_pkg;

	localparam int PATTERN_MAX = 20;
	localparam int LINE_COUNT_BITS = 16;

	// Pattern character slots held by the configuration registers.
	localparam int CHAR_SLOTS = 20;
	localparam int CHAR_IDX_W = $clog2(CHAR_SLOTS);
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CFG_LEN_W = 5;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam int LINE_TOTAL_W = 16;
	localparam int MATCH_LINE_W = 17;

	localparam logic [7:0] NEWLINE = 8'd10;

	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_LO = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_MID = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARS_HI = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 2'd3;

	typedef struct packed {
		logic [PATTERN_MAX-1:0][7:0] pattern; // entry j compares with window byte j
		logic [LEN_W-1:0]            len;
	} cfg_t;

	typedef struct packed {
		logic [LINE_TOTAL_W-1:0] line_total;
		logic [MATCH_LINE_W-1:0] first_match_line;
		logic [MATCH_LINE_W-1:0] last_match_line;
	} res_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			return c + 8'd32;
		end
		return c;
	endfunction

endpackage

[hdl/lss_cfg_regs.sv]
module lss_cfg_regs import lss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	logic [63:0]          chars_lo_q;
	logic [63:0]          chars_mid_q;
	logic [31:0]          chars_hi_q;
	logic [CFG_LEN_W-1:0] length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_lo_q  <= '0;
			chars_mid_q <= '0;
			chars_hi_q  <= '0;
			length_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHARS_LO:  chars_lo_q  <= cfg_data;
				REG_CHARS_MID: chars_mid_q <= cfg_data;
				REG_CHARS_HI:  chars_hi_q  <= cfg_data[31:0];
				REG_LENGTH:    length_q    <= cfg_data[CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CHAR_SLOTS-1:0][7:0] chars;
	logic [LEN_W-1:0]           len;

	assign chars = {chars_hi_q, chars_mid_q, chars_lo_q};

	always_comb begin
		if (int'(length_q) > PATTERN_MAX) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = LEN_W'(length_q);
		end
	end

	// The pattern is stored reversed against the window, so that its last
	// character lines up with the newest byte.
	always_comb begin
		int k;
		cfg.len = len;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			k = int'(len) - 1 - j;
			if (k >= 0 && k < CHAR_SLOTS) begin
				cfg.pattern[j] = fold(chars[CHAR_IDX_W'(k)]);
			end else begin
				cfg.pattern[j] = 8'd0;
			end
		end
	end

endmodule

[hdl/lss_line_engine.sv]
module lss_line_engine import lss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	input  logic       end_of_stream,
	input  cfg_t       cfg,
	output res_t       res
);

	logic [PATTERN_MAX-1:0][7:0]  win_q;
	logic [LEN_W-1:0]             bil_q;
	logic                         has_match_q;
	logic [LINE_COUNT_BITS-1:0]   line_q;
	logic [LINE_COUNT_BITS:0]     first_q;
	logic [LINE_COUNT_BITS:0]     last_q;

	logic [PATTERN_MAX-1:0][7:0]  win_n;
	logic [LEN_W-1:0]             bil_n;
	logic [PATTERN_MAX-1:0]       hit_vec;
	logic                         window_hit;
	logic                         line_hit;
	logic [LINE_COUNT_BITS-1:0]   line_n;
	logic [LINE_COUNT_BITS:0]     first_n;
	logic [LINE_COUNT_BITS:0]     last_n;
	logic                         is_newline;
	logic [63:0]                  total_wide;
	logic [63:0]                  first_wide;
	logic [63:0]                  last_wide;

	always_comb begin
		win_n[0] = fold(text_byte);
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	assign bil_n = (int'(bil_q) == PATTERN_MAX) ? bil_q : bil_q + 1'b1;

	// Window bytes beyond the pattern length always count as equal.
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			hit_vec[j] = (j >= int'(cfg.len)) || (win_n[j] == cfg.pattern[j]);
		end
	end

	assign window_hit = (cfg.len != '0) && (bil_n >= cfg.len) && (&hit_vec);

	// Values after closing the current line.
	assign line_hit = has_match_q || (cfg.len == '0);
	assign line_n   = (&line_q) ? line_q : line_q + 1'b1;

	always_comb begin
		first_n = first_q;
		last_n  = last_q;
		if (line_hit) begin
			if (first_q[LINE_COUNT_BITS]) begin
				first_n = {1'b0, line_n};
			end
			last_n = {1'b0, line_n};
		end
	end

	assign total_wide           = 64'(line_n);
	assign first_wide           = 64'(first_n);
	assign last_wide            = 64'(last_n);
	assign res.line_total       = total_wide[LINE_TOTAL_W-1:0];
	assign res.first_match_line = first_wide[MATCH_LINE_W-1:0];
	assign res.last_match_line  = last_wide[MATCH_LINE_W-1:0];

	assign is_newline = (text_byte == NEWLINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			bil_q       <= '0;
			has_match_q <= 1'b0;
			line_q      <= '0;
			first_q     <= '1;
			last_q      <= '1;
		end else if (step) begin
			if (end_of_stream) begin
				win_q       <= '0;
				bil_q       <= '0;
				has_match_q <= 1'b0;
				line_q      <= '0;
				first_q     <= '1;
				last_q      <= '1;
			end else if (is_newline) begin
				win_q       <= '0;
				bil_q       <= '0;
				has_match_q <= 1'b0;
				line_q      <= line_n;
				first_q     <= first_n;
				last_q      <= last_n;
			end else begin
				win_q       <= win_n;
				bil_q       <= bil_n;
				has_match_q <= has_match_q || window_hit;
			end
		end
	end

	a_clear_after_summary: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_stream |=> line_q == '0 && bil_q == '0 && first_q[LINE_COUNT_BITS]
			&& last_q[LINE_COUNT_BITS])
		else $error("stream state not cleared after summary");

	a_first_not_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q[LINE_COUNT_BITS] |-> !last_q[LINE_COUNT_BITS] && first_q <= last_q)
		else $error("first match line after last match line");

endmodule

[hdl/line_substring_search.sv]
// Per-line, case-insensitive substring search over a byte stream.
// The input channel (in_valid, in_stall) carries one request per text byte:
// text_byte, plus end_of_stream which closes the last line instead. Each
// line is searched for the pattern held in the configuration registers,
// written through cfg_wr_en, cfg_index and cfg_data while the block is idle.
// A newline closes a line and produces nothing on the output channel.
// An end-of-stream request closes the final line and produces one summary
// on the output channel (out_valid, out_stall): the line count and the
// first and last matching line, -1 when no line matched.
// A request is registered at acceptance in the input register and then
// processed against the line state, and its summary is registered in the
// output register. One request is taken every cycle unless in_stall is
// raised; the line state update is a loop through its registers and sets that rate.
// While a summary waits behind out_stall, text bytes keep flowing; only a
// second end-of-stream request holds in the input register and raises
// in_stall until the first summary is taken.
// Reset clears the pattern, the line state and both channels.
module line_substring_search import lss_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           end_of_stream,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [LINE_TOTAL_W-1:0]        line_total,
	output logic signed [MATCH_LINE_W-1:0] first_match_line,
	output logic signed [MATCH_LINE_W-1:0] last_match_line,
	input  logic                           cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       advance;
	logic       fire;

	lss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Only a summary needs the output register free.
	assign advance  = !(eos_s1 && out_valid && out_stall);
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			eos_s1  <= end_of_stream;
		end
	end

	lss_line_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (fire),
		.text_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire && eos_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && eos_s1) begin
			line_total       <= res.line_total;
			first_match_line <= res.first_match_line;
			last_match_line  <= res.last_match_line;
		end
	end

	a_stall_only_for_summary: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> eos_s1 && out_valid && out_stall)
		else $error("input stalled without a pending summary");

	a_result_only_from_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !(fire && eos_s1)) |=> !out_valid)
		else $error("summary shown without an end-of-stream request");

endmodule

[tb/lss_summary_checker.sv]
`timescale 1ns / 1ps

module lss_summary_checker import lss_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           end_of_stream,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [LINE_TOTAL_W-1:0]        line_total,
	input  logic signed [MATCH_LINE_W-1:0] first_match_line,
	input  logic signed [MATCH_LINE_W-1:0] last_match_line,
	input  logic                           cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	output int                             mismatches,
	output int                             pending,
	output int                             checked
);

	localparam logic [LINE_TOTAL_W-1:0] LINE_CEILING = '1;
	localparam logic signed [MATCH_LINE_W-1:0] NO_LINE = '1;

	logic [63:0] chars_lo = '0;
	logic [63:0] chars_mid = '0;
	logic [31:0] chars_hi = '0;
	logic [CFG_LEN_W-1:0] len_reg = '0;

	// Folded bytes of the current line, newest in entry 0.
	logic [7:0] window [PATTERN_MAX];
	int fill;
	bit line_hit;
	logic [LINE_TOTAL_W-1:0] lines_closed;
	logic signed [MATCH_LINE_W-1:0] first_line;
	logic signed [MATCH_LINE_W-1:0] last_line;

	res_t awaited_summaries[$];
	res_t oldest;
	int errs = 0;
	int seen = 0;

	initial begin
		mismatches = 0;
		pending = 0;
		checked = 0;
	end

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] pattern_at(input int k);
		if (k < 8) begin
			return lower(chars_lo[8*k +: 8]);
		end
		if (k < 16) begin
			return lower(chars_mid[8*(k-8) +: 8]);
		end
		return lower(chars_hi[8*(k-16) +: 8]);
	endfunction

	function automatic int used_length();
		return (len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
	endfunction

	task automatic clear_line();
		int k;
		for (k = 0; k < PATTERN_MAX; k++) begin
			window[k] = 8'h00;
		end
		fill = 0;
		line_hit = 1'b0;
	endtask

	task automatic clear_stream();
		clear_line();
		lines_closed = '0;
		first_line = NO_LINE;
		last_line = NO_LINE;
	endtask

	task automatic close_line();
		bit hit;
		hit = line_hit || used_length() == 0;
		if (lines_closed != LINE_CEILING) begin
			lines_closed++;
		end
		if (hit) begin
			if (first_line < 0) begin
				first_line = {1'b0, lines_closed};
			end
			last_line = {1'b0, lines_closed};
		end
		clear_line();
	endtask

	task automatic absorb_request(input logic [7:0] b, input logic eos);
		res_t s;
		int n;
		int k;
		bit same;
		if (eos) begin
			close_line();
			s.line_total = lines_closed;
			s.first_match_line = first_line;
			s.last_match_line = last_line;
			awaited_summaries.push_back(s);
			clear_stream();
		end else if (b == NEWLINE) begin
			close_line();
		end else begin
			for (k = PATTERN_MAX - 1; k > 0; k--) begin
				window[k] = window[k-1];
			end
			window[0] = lower(b);
			if (fill < PATTERN_MAX) begin
				fill++;
			end
			n = used_length();
			// The window matches when its newest n bytes spell the pattern.
			if (n != 0 && fill >= n) begin
				same = 1'b1;
				for (k = 0; k < n; k++) begin
					if (window[n-1-k] != pattern_at(k)) begin
						same = 1'b0;
					end
				end
				if (same) begin
					line_hit = 1'b1;
				end
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		errs++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_lo = '0;
			chars_mid = '0;
			chars_hi = '0;
			len_reg = '0;
			clear_stream();
			awaited_summaries.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CHARS_LO:  chars_lo = cfg_data;
					REG_CHARS_MID: chars_mid = cfg_data;
					REG_CHARS_HI:  chars_hi = cfg_data[31:0];
					REG_LENGTH:    len_reg = cfg_data[CFG_LEN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen++;
				if (awaited_summaries.size() == 0) begin
					report_mismatch($sformatf("summary %0d arrived with none outstanding (%0d, %0d, %0d)",
						seen, line_total, first_match_line, last_match_line));
				end else begin
					oldest = awaited_summaries.pop_front();
					if (line_total !== oldest.line_total) begin
						report_mismatch($sformatf("summary %0d line_total %0d, predicted %0d",
							seen, line_total, oldest.line_total));
					end
					if (first_match_line !== oldest.first_match_line) begin
						report_mismatch($sformatf("summary %0d first_match_line %0d, predicted %0d",
							seen, first_match_line, $signed(oldest.first_match_line)));
					end
					if (last_match_line !== oldest.last_match_line) begin
						report_mismatch($sformatf("summary %0d last_match_line %0d, predicted %0d",
							seen, last_match_line, $signed(oldest.last_match_line)));
					end
				end
			end
			if (in_valid && !in_stall) begin
				absorb_request(text_byte, end_of_stream);
			end
		end
		mismatches <= errs;
		pending <= awaited_summaries.size();
		checked <= seen;
	end

endmodule

[tb/line_substring_search_tb.sv]
`timescale 1ns / 1ps

module line_substring_search_tb;
	import lss_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1850;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_byte = 8'h00;
	logic end_of_stream = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [LINE_TOTAL_W-1:0] line_total;
	logic signed [MATCH_LINE_W-1:0] first_match_line;
	logic signed [MATCH_LINE_W-1:0] last_match_line;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_CHARS_LO;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;
	int checked;

	// Raw pattern bytes as last written, and the number of them in use.
	logic [7:0] pat [PATTERN_MAX];
	int pat_use = 0;
	int requests = 0;
	int settings = 0;
	bit calm = 1'b0;
	int cycles = 0;
	int stall_left = 0;
	int base;
	int streams;
	int lines;
	int i;
	int forced_lengths[4] = '{31, 20, 0, 21};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	line_substring_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_total(line_total),
		.first_match_line(first_match_line),
		.last_match_line(last_match_line),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lss_summary_checker summary_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_total(line_total),
		.first_match_line(first_match_line),
		.last_match_line(last_match_line),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// The receiver alternates between stall stretches and free stretches.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
		end else if ($urandom_range(0, 99) < 40) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
		end else begin
			out_stall <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 6);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d summaries outstanding", cycles, pending);
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [7:0] filler();
		case ($urandom_range(0, 3))
			0: return "a";
			1: return "A";
			2: return "b";
			default: return "B";
		endcase
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] c);
		bit letter;
		letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		return (letter && $urandom_range(0, 1) == 1) ? c ^ 8'h20 : c;
	endfunction

	function automatic logic [7:0] text_char();
		if (pat_use != 0 && $urandom_range(0, 1) == 1) begin
			return flip_case(pat[$urandom_range(0, pat_use - 1)]);
		end
		return filler();
	endfunction

	task automatic send(input logic [7:0] b, input logic eos);
		int gap;
		gap = next_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		requests++;
	endtask

	// Lets every outstanding summary arrive and the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [63:0] lo, input logic [63:0] mid,
			input logic [63:0] hi, input logic [63:0] len_word);
		int k;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CHARS_LO;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_CHARS_MID;
		cfg_data <= mid;
		@(posedge clk);
		cfg_index <= REG_CHARS_HI;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= REG_LENGTH;
		cfg_data <= len_word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		for (k = 0; k < PATTERN_MAX; k++) begin
			pat[k] = (k < 8) ? lo[8*k +: 8] : (k < 16) ? mid[8*(k-8) +: 8] : hi[8*(k-16) +: 8];
		end
		pat_use = (len_word[4:0] > PATTERN_MAX) ? PATTERN_MAX : int'(len_word[4:0]);
		settings++;
	endtask

	task automatic set_pattern(input int length_code);
		logic [63:0] lo;
		logic [63:0] mid;
		logic [63:0] hi;
		logic [63:0] len_word;
		logic [7:0] c;
		bit wild;
		int k;
		wild = ($urandom_range(0, 4) == 0);
		for (k = 0; k < PATTERN_MAX; k++) begin
			if (wild) begin
				c = 8'($urandom_range(0, 255));
			end else if ($urandom_range(0, 9) < 7) begin
				c = filler();
			end else begin
				case ($urandom_range(0, 6))
					0: c = 8'h40;
					1: c = 8'h5B;
					2: c = 8'h60;
					3: c = 8'h7B;
					4: c = 8'h00;
					5: c = "z";
					default: c = "Z";
				endcase
			end
			if (k < 8) begin
				lo[8*k +: 8] = c;
			end else if (k < 16) begin
				mid[8*(k-8) +: 8] = c;
			end else begin
				hi[8*(k-16) +: 8] = c;
			end
		end
		// Bits above each register's width are junk the block must drop.
		hi[63:32] = $urandom;
		len_word = {$urandom, $urandom};
		len_word[4:0] = 5'(length_code);
		write_regs(lo, mid, hi, len_word);
	endtask

	task automatic send_pattern();
		int k;
		for (k = 0; k < pat_use; k++) begin
			send(flip_case(pat[k]), 1'b0);
		end
	endtask

	task automatic send_line(input bit last);
		int kind;
		int k;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			repeat ($urandom_range(0, 8)) send(text_char(), 1'b0);
			send_pattern();
			repeat ($urandom_range(0, 8)) send(text_char(), 1'b0);
		end else if (kind < 62) begin
			// Near miss: all but the final pattern character.
			for (k = 0; k + 1 < pat_use; k++) begin
				send(flip_case(pat[k]), 1'b0);
			end
			send(text_char(), 1'b0);
		end else if (kind < 72) begin
			repeat ($urandom_range(21, 60)) send(text_char(), 1'b0);
			send_pattern();
		end else if (kind < 85) begin
			repeat ($urandom_range(0, 25)) send(text_char(), 1'b0);
		end else begin
			repeat ($urandom_range(0, 12)) send(8'($urandom_range(0, 255)), 1'b0);
		end
		if (!last || $urandom_range(0, 3) == 0) begin
			send(NEWLINE, 1'b0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset pattern empty, the lone final line matches.
		send(8'h00, 1'b1);
		drain();

		// Pattern "@Z" plus a zero byte; the bytes beyond the length are ignored.
		write_regs(64'h7878_7878_7800_5A40, '1, '1, 64'hFFFF_FFFF_FFFF_FFE3);
		send(8'h40, 1'b0);
		send("z", 1'b0);
		send(8'h00, 1'b0);
		send(NEWLINE, 1'b0);
		send(8'h5B, 1'b0);
		send(8'h60, 1'b0);
		send("Z", 1'b0);
		send(8'h00, 1'b0);
		send(NEWLINE, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h7B, 1'b0);
		send("@", 1'b0);
		send("Z", 1'b0);
		send(8'h00, 1'b0);
		send(NEWLINE, 1'b0);
		send(NEWLINE, 1'b1);
		send(8'hFF, 1'b1);
		drain();

		base = requests;
		i = 0;
		while (requests - base < RANDOM_ITEMS) begin
			if (i < 4) begin
				set_pattern(forced_lengths[i]);
			end else begin
				case ($urandom_range(0, 9))
					0: set_pattern(0);
					1: set_pattern($urandom_range(16, 31));
					default: set_pattern($urandom_range(1, 6));
				endcase
			end
			i++;
			streams = $urandom_range(1, 3);
			repeat (streams) begin
				calm = ($urandom_range(0, 4) == 0);
				lines = $urandom_range(0, 4);
				for (int n = 0; n < lines; n++) begin
					send_line(n == lines - 1);
				end
				send(8'($urandom_range(0, 255)), 1'b1);
			end
			calm = 1'b0;
			drain();
		end

		$display("%0d requests sent, %0d summaries checked over %0d pattern settings",
			requests, checked, settings);
		$display("covered empty, oversized and arbitrary patterns, zero bytes, long lines and %s",
			"streams that follow each other with no gap");
		if (mismatches == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
